FILE: hdl/qsu_pkg.sv
package qsu_pkg;

  // One input beat: a character, or the end-of-text marker.
  typedef struct packed {
    logic       kind;
    logic [7:0] char_byte;
  } in_t;

  // One result beat.
  typedef struct packed {
    logic       data_valid;
    logic [7:0] data_byte;
    logic       string_done;
    logic [2:0] error_code;
  } out_t;

  // Error codes.
  localparam logic [2:0] ERR_NONE    = 3'd0;
  localparam logic [2:0] ERR_NO_OPEN = 3'd1;
  localparam logic [2:0] ERR_BAD_ESC = 3'd2;
  localparam logic [2:0] ERR_BAD_HEX = 3'd3;
  localparam logic [2:0] ERR_END_HEX = 3'd4;
  localparam logic [2:0] ERR_UNTERM  = 3'd5;

  // Character codes.
  localparam logic [7:0] CH_NUL       = 8'h00;
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_X         = 8'h78;
  localparam logic [7:0] CH_A         = 8'h61;
  localparam logic [7:0] CH_B         = 8'h62;
  localparam logic [7:0] CH_N         = 8'h6E;
  localparam logic [7:0] CH_R         = 8'h72;
  localparam logic [7:0] CH_T         = 8'h74;

  // Byte values of the escapes.
  localparam logic [7:0] BYTE_BEL = 8'h07;
  localparam logic [7:0] BYTE_BS  = 8'h08;
  localparam logic [7:0] BYTE_LF  = 8'h0A;
  localparam logic [7:0] BYTE_CR  = 8'h0D;
  localparam logic [7:0] BYTE_TAB = 8'h09;

endpackage

FILE: hdl/quoted_string_unescaper.sv
// A character beat taken into the input stage register moves on to the result register,
// which drives out_valid, once that register is free; a stalled output holds it back.
// Throughput: one character per cycle; the input register and the result register
// form a two-stage pipeline, and the input side keeps accepting while out_stall is low.
// Reset (rst_n low, synchronous): both stages empty, decoder waiting for an opening quote.
module quoted_string_unescaper (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  qsu_pkg::in_t    in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output qsu_pkg::out_t   out_data
);
  import qsu_pkg::*;

  // Decoder modes. The encoding is only three bits wide; unused codes are never reached.
  typedef enum logic [2:0] {
    MODE_WAIT,
    MODE_BODY,
    MODE_ESC,
    MODE_HEX1,
    MODE_HEX2
  } mode_t;

  // Input stage register.
  logic       s1_valid_r, s1_valid_nxt;
  in_t        s1_data_r,  s1_data_nxt;

  // Result stage register.
  logic       out_valid_r, out_valid_nxt;
  out_t       out_data_r,  out_data_nxt;

  // Decoder state. It advances only when the item in the input stage moves on.
  mode_t      mode_r, mode_nxt;
  logic [3:0] high_nibble_r, high_nibble_nxt;

  logic       out_free;
  logic       in_take;
  logic       s1_move;
  logic       is_end;
  logic [4:0] hex_val;
  out_t       result;
  mode_t      mode_calc;
  logic [3:0] nibble_calc;

  // Returns 0 to 15 for a hex digit of either case, and 16 for anything else.
  function automatic logic [4:0] hex_value(input logic [7:0] ch);
    logic [7:0] d;
    begin
      d = 8'h00;
      hex_value = 5'd16;
      if (ch >= 8'h30 && ch <= 8'h39) begin
        d = ch - 8'h30;
        hex_value = {1'b0, d[3:0]};
      end else if (ch >= 8'h61 && ch <= 8'h66) begin
        d = ch - 8'h57;
        hex_value = {1'b0, d[3:0]};
      end else if (ch >= 8'h41 && ch <= 8'h46) begin
        d = ch - 8'h37;
        hex_value = {1'b0, d[3:0]};
      end
    end
  endfunction

  // Flow control. The result register is free when it is empty or its beat leaves this
  // cycle. The input stage hands its beat over whenever the result register is free,
  // so the input side only stalls while both stages are occupied and the output stalls.
  assign out_free = !out_valid_r || !out_stall;
  assign s1_move  = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;
  assign in_take  = in_valid && !in_stall;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Decode of the character held in the input stage against the current mode.
  // A zero byte counts as end of text, the same as the end-of-text kind.
  always_comb begin
    is_end      = s1_data_r.kind || (s1_data_r.char_byte == CH_NUL);
    hex_val     = hex_value(s1_data_r.char_byte);
    result      = '0;
    mode_calc   = mode_r;
    nibble_calc = high_nibble_r;

    case (mode_r)
      MODE_BODY: begin
        if (is_end) begin
          result.error_code = ERR_UNTERM;
          mode_calc         = MODE_WAIT;
        end else if (s1_data_r.char_byte == CH_BACKSLASH) begin
          mode_calc = MODE_ESC;
        end else if (s1_data_r.char_byte == CH_QUOTE) begin
          result.string_done = 1'b1;
          mode_calc          = MODE_WAIT;
        end else begin
          result.data_valid = 1'b1;
          result.data_byte  = s1_data_r.char_byte;
        end
      end
      MODE_ESC: begin
        if (is_end) begin
          // The text ended right after a backslash: the string was never closed.
          result.error_code = ERR_UNTERM;
          mode_calc         = MODE_WAIT;
        end else begin
          mode_calc         = MODE_BODY;
          result.data_valid = 1'b1;
          case (s1_data_r.char_byte)
            CH_BACKSLASH: result.data_byte = CH_BACKSLASH;
            CH_A:         result.data_byte = BYTE_BEL;
            CH_B:         result.data_byte = BYTE_BS;
            CH_N:         result.data_byte = BYTE_LF;
            CH_R:         result.data_byte = BYTE_CR;
            CH_T:         result.data_byte = BYTE_TAB;
            CH_QUOTE:     result.data_byte = CH_QUOTE;
            CH_X: begin
              result.data_valid = 1'b0;
              mode_calc         = MODE_HEX1;
            end
            default: begin
              result.data_valid = 1'b0;
              result.error_code = ERR_BAD_ESC;
              mode_calc         = MODE_WAIT;
            end
          endcase
        end
      end
      MODE_HEX1, MODE_HEX2: begin
        if (is_end) begin
          result.error_code = ERR_END_HEX;
          mode_calc         = MODE_WAIT;
        end else if (hex_val[4]) begin
          // The first bad digit is reported at once.
          result.error_code = ERR_BAD_HEX;
          mode_calc         = MODE_WAIT;
        end else if (mode_r == MODE_HEX1) begin
          nibble_calc = hex_val[3:0];
          mode_calc   = MODE_HEX2;
        end else begin
          result.data_valid = 1'b1;
          result.data_byte  = {high_nibble_r, hex_val[3:0]};
          mode_calc         = MODE_BODY;
        end
      end
      default: begin
        // Waiting for the opening quote. End of text here is silently ignored.
        mode_calc = MODE_WAIT;
        if (!is_end) begin
          if (s1_data_r.char_byte == CH_QUOTE) begin
            mode_calc = MODE_BODY;
          end else begin
            result.error_code = ERR_NO_OPEN;
          end
        end
      end
    endcase
  end

  // Next-state values for both stages and the decoder state.
  always_comb begin
    s1_valid_nxt    = in_take ? 1'b1 : (s1_move ? 1'b0 : s1_valid_r);
    s1_data_nxt     = in_take ? in_data : s1_data_r;
    out_valid_nxt   = out_free ? s1_valid_r : out_valid_r;
    out_data_nxt    = s1_move ? result : out_data_r;
    mode_nxt        = s1_move ? mode_calc : mode_r;
    high_nibble_nxt = s1_move ? nibble_calc : high_nibble_r;
  end

  // Payload registers follow their next values; reset clears only the control state.
  always_ff @(posedge clk) begin
    s1_data_r  <= s1_data_nxt;
    out_data_r <= out_data_nxt;
    if (!rst_n) begin
      s1_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      mode_r        <= MODE_WAIT;
      high_nibble_r <= 4'h0;
    end else begin
      s1_valid_r    <= s1_valid_nxt;
      out_valid_r   <= out_valid_nxt;
      mode_r        <= mode_nxt;
      high_nibble_r <= high_nibble_nxt;
    end
  end

`ifndef SYNTHESIS
  // Any item that reports an error leaves the decoder waiting for a new string.
  assert property (@(posedge clk) disable iff (!rst_n)
    (s1_move && result.error_code != ERR_NONE) |=> (mode_r == MODE_WAIT))
    else $error("decoder not back to waiting after an error");

  // A closing quote also returns the decoder to waiting.
  assert property (@(posedge clk) disable iff (!rst_n)
    (s1_move && result.string_done) |=> (mode_r == MODE_WAIT))
    else $error("decoder not back to waiting after the closing quote");

  // A result beat carries at most one of: a byte, completion, an error.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ($countones({out_data_r.data_valid, out_data_r.string_done,
                                 out_data_r.error_code != ERR_NONE}) <= 1))
    else $error("result beat carries conflicting flags");

  // A beat in the input stage that may not move must still be there next cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !out_free) |=> (s1_valid_r && $stable(s1_data_r)))
    else $error("input stage lost a beat while the output was stalled");

  // The decoder state only changes when an item is handed to the result register.
  assert property (@(posedge clk) disable iff (!rst_n)
    !s1_move |=> ($stable(mode_r) && $stable(high_nibble_r)))
    else $error("decoder state changed without an item");
`endif

endmodule
